[src/eftc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eftc_pkg
// Shared types, request and curve codes for the fade tween controller.
// ----------------------------------------------------------------------------
package eftc_pkg;

	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_BLEND = 2'd1;
	localparam logic [1:0] REQ_TINT  = 2'd2;

	localparam logic [2:0] CURVE_SET    = 3'd0;
	localparam logic [2:0] CURVE_LINEAR = 3'd1;
	localparam logic [2:0] CURVE_COSINE = 3'd2;
	localparam logic [2:0] CURVE_SQUARE = 3'd3;
	localparam logic [2:0] CURVE_LOG    = 3'd4;

	// start request and sequencer rate for a mixing lane
	typedef struct packed {
		logic start;
		logic [15:0] rate;
	} lane_ctl_t;

endpackage

[src/eftc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eftc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module eftc_div #(
	parameter int NUM_BITS = 40,
	parameter int DEN_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] num,
	input  logic [DEN_BITS-1:0] den,
	output logic                done,
	output logic [NUM_BITS-1:0] quo,
	output logic [DEN_BITS-1:0] rem
);
	localparam int CW = $clog2(NUM_BITS + 1);

	logic [NUM_BITS-1:0] n_q;
	logic [DEN_BITS:0]   r_q;
	logic [DEN_BITS-1:0] d_q;
	logic [CW-1:0]       cnt_q;
	logic                busy_q;
	logic [DEN_BITS:0]   trial;
	logic [DEN_BITS+1:0] diff;

	assign trial = {r_q[DEN_BITS-1:0], n_q[NUM_BITS-1]};
	assign diff  = {1'b0, trial} - {2'b00, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
		end else if (busy_q) begin
			if (!diff[DEN_BITS+1]) begin
				r_q <= diff[DEN_BITS:0];
				n_q <= {n_q[NUM_BITS-2:0], 1'b1};
			end else begin
				r_q <= trial;
				n_q <= {n_q[NUM_BITS-2:0], 1'b0};
			end
		end
	end

	assign quo = n_q;
	assign rem = r_q[DEN_BITS-1:0];
endmodule

[src/eftc_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eftc_lane
// One value lane: holds start, end and current value and mixes on a rate.
// ----------------------------------------------------------------------------
module eftc_lane
	import eftc_pkg::*;
#(
	parameter logic signed [15:0] RESET_VAL = 16'sd0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lane_ctl_t          ctl,
	input  logic               jump,
	input  logic               mix_en,
	input  logic               fin,
	input  logic signed [15:0] end_in,
	output logic signed [15:0] now
);
	logic signed [15:0] start_q, end_q, now_q;
	logic signed [16:0] dlt;
	logic signed [33:0] prod;
	logic signed [19:0] sh;
	logic signed [20:0] sum;

	assign dlt  = 17'(end_q) - 17'(start_q);
	assign prod = 34'(dlt) * $signed({18'd0, ctl.rate}) + 34'sd8192;
	assign sh   = 20'(prod >>> 14);
	assign sum  = 21'(start_q) + 21'(sh);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= RESET_VAL;
			end_q   <= RESET_VAL;
			now_q   <= RESET_VAL;
		end else if (ctl.start) begin
			end_q   <= end_in;
			start_q <= now_q;
			if (jump) now_q <= end_in;
		end else if (fin) begin
			now_q <= end_q;
		end else if (mix_en) begin
			if (sum > 21'sd32767)       now_q <= 16'sh7fff;
			else if (sum < -21'sd32768) now_q <= 16'sh8000;
			else                        now_q <= sum[15:0];
		end
	end
	assign now = now_q;
endmodule

[src/eftc_track.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eftc_track
// Frame counter and rate sequencer for one track; uses its own divider instance.
// ----------------------------------------------------------------------------
module eftc_track
	import eftc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [2:0]  curve,
	input  logic [15:0] duration,
	input  logic        tick,
	output logic        busy,
	output logic        mix_en,
	output logic        fin,
	output logic [15:0] rate,
	output logic        done
);
	localparam logic [2:0] ST_IDLE = 3'd0, ST_DIV1 = 3'd1, ST_W1 = 3'd2,
		ST_TAB = 3'd3, ST_DIV2 = 3'd4, ST_W2 = 3'd5, ST_SQ = 3'd6, ST_MIX = 3'd7;
	localparam logic [63:0] Q30 = 64'd1 << 30;

	logic [2:0]  st_q;
	logic [15:0] fr_q, len_q, rate_q;
	logic [2:0]  cur_q;
	logic [15:0] f1;
	logic        dstart, ddone;
	logic [39:0] dnum, dquo;
	logic [23:0] dden, drem;
	logic [15:0] t0, t1, tdiff;
	logic [31:0] sq;
	logic [8:0]  idx_q;
	logic [15:0] t0_q;
	logic [15:0] tab_a, tab_b;
	logic [15:0] cos_lut [257];
	logic [15:0] log_lut [257];

	assign f1 = fr_q + 16'd1;

	eftc_div #(.NUM_BITS(40), .DEN_BITS(24)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(dnum), .den(dden),
		.done(ddone), .quo(dquo), .rem(drem)
	);

	function automatic logic [15:0] q30_to_q14(input logic [63:0] v);
		logic [63:0] r;
		r = (v + 64'd32768) >> 16;
		return (r > 64'd16384) ? 16'd16384 : r[15:0];
	endfunction

	// sin^2(pi/2*i/256) from a Q30 Taylor series
	function automatic logic [15:0] cos_entry(input int i);
		logic [63:0] x, t, t2, acc, s;
		x   = 64'(i) << 22;
		t   = (x * 64'd1686629713) >> 30;
		t2  = (t * t) >> 30;
		acc = Q30;
		acc = Q30 - ((t2 * acc) >> 30) / 64'd156;
		acc = Q30 - ((t2 * acc) >> 30) / 64'd110;
		acc = Q30 - ((t2 * acc) >> 30) / 64'd72;
		acc = Q30 - ((t2 * acc) >> 30) / 64'd42;
		acc = Q30 - ((t2 * acc) >> 30) / 64'd20;
		acc = Q30 - ((t2 * acc) >> 30) / 64'd6;
		s   = (t * acc) >> 30;
		return q30_to_q14((s * s) >> 30);
	endfunction

	// log10(1+9*i/256): bitwise Q30 log2, then scale by log10(2)
	function automatic logic [15:0] log_entry(input int i);
		logic [63:0] m, lg;
		logic [1:0]  ip;
		m  = Q30 + 64'd9 * (64'(i) << 22);
		ip = 2'd0;
		for (int j = 0; j < 3; j++) begin
			if (m >= (Q30 << 1)) begin
				m  = m >> 1;
				ip = ip + 2'd1;
			end
		end
		lg = 64'(ip) << 30;
		for (int k = 29; k >= 0; k--) begin
			m = (m * m) >> 30;
			if (m >= (Q30 << 1)) begin
				m  = m >> 1;
				lg = lg | (64'd1 << k);
			end
		end
		return q30_to_q14((lg * 64'd323228497) >> 30);
	endfunction

	// curve tables, folded to constants at elaboration
	for (genvar gi = 0; gi <= 256; gi++) begin : g_lut
		assign cos_lut[gi] = cos_entry(gi);
		assign log_lut[gi] = log_entry(gi);
	end

	function automatic logic [15:0] tab_val(input logic [2:0] c, input logic [8:0] i);
		return (c == CURVE_COSINE) ? cos_lut[i] : log_lut[i];
	endfunction

	assign t0    = tab_a;
	assign t1    = tab_b;
	assign tab_a = tab_val(cur_q, idx_q);
	assign tab_b = (idx_q >= 9'd256) ? tab_a : tab_val(cur_q, idx_q + 9'd1);
	assign tdiff = (t1 < t0) ? 16'd0 : t1 - t0;
	assign sq    = 32'(rate_q) * 32'(rate_q);

	always_comb begin
		dstart = 1'b0;
		dnum   = '0;
		dden   = 24'(len_q);
		case (st_q)
			ST_IDLE: begin
				dnum = (cur_q == CURVE_LINEAR || cur_q == CURVE_SQUARE)
					? 40'(f1) << 14 : 40'(f1) << 8;
				dstart = tick && fr_q < len_q && f1 != len_q
					&& (cur_q >= CURVE_LINEAR && cur_q <= CURVE_LOG);
			end
			ST_TAB: begin
				dnum   = 40'(tdiff) * 40'(drem);
				dstart = idx_q < 9'd256;
			end
			default: dnum = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; fr_q <= '0; len_q <= '0; cur_q <= CURVE_SET;
			rate_q <= '0; idx_q <= '0; t0_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (start) begin
						fr_q <= '0; len_q <= duration; cur_q <= curve;
					end else if (tick && fr_q < len_q) begin
						fr_q <= f1;
						if (dstart) st_q <= ST_DIV1;
						else if (f1 != len_q) begin
							rate_q <= 16'd16384; st_q <= ST_MIX;
						end
					end
				end
				ST_DIV1: st_q <= ST_W1;
				ST_W1: if (ddone) begin
					if (cur_q == CURVE_LINEAR) begin
						rate_q <= 16'(dquo); st_q <= ST_MIX;
					end else if (cur_q == CURVE_SQUARE) begin
						rate_q <= 16'(dquo); st_q <= ST_SQ;
					end else begin
						idx_q <= (dquo >= 40'd256) ? 9'd256 : 9'(dquo);
						st_q  <= ST_TAB;
					end
				end
				ST_SQ: begin rate_q <= 16'(sq >> 14); st_q <= ST_MIX; end
				ST_TAB: begin
					t0_q <= tab_a;
					if (idx_q >= 9'd256) begin rate_q <= tab_a; st_q <= ST_MIX; end
					else st_q <= ST_DIV2;
				end
				ST_DIV2: st_q <= ST_W2;
				ST_W2: if (ddone) begin
					rate_q <= t0_q + 16'(dquo); st_q <= ST_MIX;
				end
				ST_MIX: st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign busy   = st_q != ST_IDLE;
	assign mix_en = st_q == ST_MIX;
	assign fin    = st_q == ST_IDLE && tick && fr_q < len_q && f1 == len_q;
	assign rate   = (rate_q > 16'd16384) ? 16'd16384 : rate_q;
	assign done   = fr_q >= len_q;

	a_mix: assert property (@(posedge clk) disable iff (!arst_n) !(mix_en && fr_q >= len_q))
		else $error("mix past end");
	a_fin: assert property (@(posedge clk) disable iff (!arst_n) fin |=> done)
		else $error("fin left track open");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> fr_q == 16'd0) else $error("start kept frames");
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mix_en |=> !busy) else $error("mix did not finish");
endmodule

[src/eased_fade_tween_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eased_fade_tween_controller
// Blend and RGB tint fade engine, four lanes sharing per-track sequencers.
// ----------------------------------------------------------------------------
// Start requests, type 3, finished and last-frame ticks: pend_q, then out_valid.
// Ticks wait for the sequencers: set-like curves run no division, linear and square
// one and the tables two 40-bit serial divisions per track.
// One item at a time; in_ready returns the cycle after the result beat.
// arst_n resets control state and lanes (blend one half, tint zero); divider data is not reset.
module eased_fade_tween_controller
	import eftc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [2:0]  curve,
	input  logic [15:0] duration,
	input  logic signed [15:0] blend_target,
	input  logic signed [15:0] tint_target_r,
	input  logic signed [15:0] tint_target_g,
	input  logic signed [15:0] tint_target_b,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [14:0] alpha_out,
	output logic [14:0] add_r,
	output logic [14:0] add_g,
	output logic [14:0] add_b,
	output logic [14:0] sub_r,
	output logic [14:0] sub_g,
	output logic [14:0] sub_b,
	output logic        blend_done,
	output logic        tint_done
);
	logic acc, tick, pend_q, bbusy, tbusy, bmix, tmix, bfin, tfin, bdn, tdn;
	logic [15:0] brate, trate;
	lane_ctl_t bctl, tctl;
	logic signed [15:0] bnow, tnow [3];
	logic signed [16:0] bsum;
	logic signed [15:0] bend;
	logic jump;

	assign acc  = in_valid && in_ready;
	assign tick = acc && req_type == REQ_TICK;
	assign jump = curve == CURVE_SET || duration == 16'd0;
	assign in_ready = !pend_q && !out_valid;
	assign bsum = 17'(blend_target) + 17'sd8192;
	assign bend = bsum < 0 ? 16'sd0 : (bsum > 17'sd16384 ? 16'sd16384 : bsum[15:0]);

	assign bctl = '{start: acc && req_type == REQ_BLEND, rate: brate};
	assign tctl = '{start: acc && req_type == REQ_TINT, rate: trate};

	eftc_track u_bt (.clk(clk), .arst_n(arst_n), .start(bctl.start), .curve(curve),
		.duration(duration), .tick(tick), .busy(bbusy), .mix_en(bmix), .fin(bfin),
		.rate(brate), .done(bdn));
	eftc_track u_tt (.clk(clk), .arst_n(arst_n), .start(tctl.start), .curve(curve),
		.duration(duration), .tick(tick), .busy(tbusy), .mix_en(tmix), .fin(tfin),
		.rate(trate), .done(tdn));

	eftc_lane #(.RESET_VAL(16'sd8192)) u_lb (.clk(clk), .arst_n(arst_n), .ctl(bctl),
		.jump(jump), .mix_en(bmix), .fin(bfin), .end_in(bend), .now(bnow));
	eftc_lane u_lr (.clk(clk), .arst_n(arst_n), .ctl(tctl), .jump(jump), .mix_en(tmix),
		.fin(tfin), .end_in(tint_target_r), .now(tnow[0]));
	eftc_lane u_lg (.clk(clk), .arst_n(arst_n), .ctl(tctl), .jump(jump), .mix_en(tmix),
		.fin(tfin), .end_in(tint_target_g), .now(tnow[1]));
	eftc_lane u_lbl (.clk(clk), .arst_n(arst_n), .ctl(tctl), .jump(jump), .mix_en(tmix),
		.fin(tfin), .end_in(tint_target_b), .now(tnow[2]));

	// hold the beat until both sequencers settle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0; out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (acc) pend_q <= 1'b1;
			else if (pend_q && !bbusy && !tbusy) begin
				pend_q <= 1'b0; out_valid <= 1'b1;
			end
		end
	end

	function automatic logic [14:0] clip(input logic signed [16:0] v);
		return v < 0 ? 15'd0 : (v > 17'sd16384 ? 15'd16384 : v[14:0]);
	endfunction

	assign alpha_out = clip(17'(bnow));
	assign add_r = clip(17'(tnow[0]));
	assign add_g = clip(17'(tnow[1]));
	assign add_b = clip(17'(tnow[2]));
	assign sub_r = tnow[0] < 0 ? clip(-17'(tnow[0])) : 15'd0;
	assign sub_g = tnow[1] < 0 ? clip(-17'(tnow[1])) : 15'd0;
	assign sub_b = tnow[2] < 0 ? clip(-17'(tnow[2])) : 15'd0;
	assign blend_done = bdn;
	assign tint_done  = tdn;

	a_one: assert property (@(posedge clk) disable iff (!arst_n) acc |=> pend_q)
		else $error("beat lost");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n) !(pend_q && out_valid))
		else $error("overlap");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> !in_ready)
		else $error("ready while result waits");
endmodule
